// File: rtl/lpfp_pkg.sv
`default_nettype none

package lpfp_pkg;

   // Default width of the length and payload counters.
   localparam int LENGTH_WIDTH_DEFAULT = 32;

   // Reset value of the maximum frame length register.
   localparam logic [31:0] MAX_FRAME_LEN_RESET = 32'd65536;

   // Register map, as register indexes (byte address is four times the index).
   localparam logic [0:0] REG_MAX_FRAME_LEN = 1'b0;

   // Header characters.
   localparam logic [7:0] CHAR_START = 8'h53;  // 'S'
   localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'

   localparam logic [3:0] DECIMAL_BASE = 4'd10;

   typedef enum logic [3:0] {
      PHASE_WAIT = 4'b0001,
      PHASE_LEN  = 4'b0010,
      PHASE_DATA = 4'b0100,
      PHASE_ERR  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_HEADER  = 2'd0,
      STATUS_PAYLOAD = 2'd1,
      STATUS_PROTO   = 2'd2,
      STATUS_TOOBIG  = 2'd3
   } status_type;

endpackage

`default_nettype wire

// File: rtl/length_prefixed_frame_parser_unit.sv
`default_nettype none

// Decimal length-prefixed deframer. Each input item carries one received byte
// (req_tdata) and a new-connection flag (req_tuser); the flag clears the parser
// before that byte is handled. Frames look like 'S', decimal length digits,
// ':', then the payload. Every input item produces exactly one result item:
// a status code (header byte, payload byte, protocol error, or length too
// large), the payload byte, a last-of-frame mark on tlast and a mark for the
// connection's first (identifier) frame. A zero length still takes one
// payload byte. Errors latch until the next new connection. The block takes
// one item per clock cycle while rsp_tready is high: an item passes through
// the input register, and the parser state is updated as it moves into the
// result register, whose valid flag drives rsp_tvalid. With rsp_tready held
// high, items flow back to back. While a finished result waits for
// rsp_tready the empty input register can still take one more item; after
// that req_tready stays low until the waiting result is taken. The maximum
// frame length register sits at byte address 0 of the APB-style port,
// resets to 65536, and may only be written while no items are in flight.
module length_prefixed_frame_parser_unit
   import lpfp_pkg::*;
#(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // Input stream.
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] new_connection

   // Result stream.
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [7:0] payload_byte
   output      logic        rsp_tlast,   // last_of_frame
   output      logic [2:0]  rsp_tuser,   // [1:0] status, [2] identifier_frame

   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   // Width of the length update path: one decimal step grows the length by
   // at most four bits, and it is compared against the 32-bit maximum.
   localparam int CalcWidth = (LENGTH_WIDTH + 4 > 32) ? LENGTH_WIDTH + 4 : 32;

   localparam logic [LENGTH_WIDTH-1:0] LenMask = {LENGTH_WIDTH{1'b1}};

   // Configuration register.
   logic [31:0] max_len_ff;
   logic [31:0] max_len_in;
   logic        csr_write;
   logic        csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_MAX_FRAME_LEN);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? max_len_ff : 32'd0;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_write && csr_hit) begin
         max_len_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_FRAME_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // Input register stage.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] in_byte_in;
   logic       in_newconn_ff;
   logic       in_newconn_in;

   // Result register stage.
   logic       out_valid_ff;
   logic       out_valid_in;
   status_type out_status_ff;
   status_type out_status_in;
   logic [7:0] out_byte_ff;
   logic [7:0] out_byte_in;
   logic       out_last_ff;
   logic       out_last_in;
   logic       out_ident_ff;
   logic       out_ident_in;

   // Parser state.
   phase_type               phase_ff;
   phase_type               phase_in;
   logic [LENGTH_WIDTH-1:0] frame_len_ff;
   logic [LENGTH_WIDTH-1:0] frame_len_in;
   logic [LENGTH_WIDTH-1:0] pay_count_ff;
   logic [LENGTH_WIDTH-1:0] pay_count_in;
   logic                    first_pending_ff;
   logic                    first_pending_in;

   // The item in the input register moves on when the result register is
   // empty or its item is taken in this cycle.
   logic advance;
   logic accept;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_byte_in    = in_byte_ff;
      in_newconn_in = in_newconn_ff;
      if (accept) begin
         in_valid_in   = 1'b1;
         in_byte_in    = req_tdata;
         in_newconn_in = req_tuser;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Parser step. A new connection first puts the state back to its reset
   // values, then the byte is handled against that cleared state.
   phase_type               cur_phase;
   logic [LENGTH_WIDTH-1:0] cur_len;
   logic [LENGTH_WIDTH-1:0] cur_count;
   logic                    cur_first;
   logic                    is_digit;
   logic [3:0]              digit;
   logic [CalcWidth-1:0]    len_ext;
   logic [CalcWidth-1:0]    len_next;
   logic                    too_big;
   logic [LENGTH_WIDTH-1:0] count_inc;

   always_comb begin
      if (in_newconn_ff) begin
         cur_phase = PHASE_WAIT;
         cur_len   = '0;
         cur_count = '0;
         cur_first = 1'b1;
      end else begin
         cur_phase = phase_ff;
         cur_len   = frame_len_ff;
         cur_count = pay_count_ff;
         cur_first = first_pending_ff;
      end
   end

   assign is_digit = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign digit    = 4'(in_byte_ff - CHAR_ZERO);
   assign len_ext  = CalcWidth'(cur_len);

   // Times ten as two shifts and an add; the length is never above the
   // limit, so the sum fits in four bits more than the length.
   assign len_next = (len_ext << 3) + (len_ext << 1) + CalcWidth'(digit);
   assign too_big  = (len_next > CalcWidth'(max_len_ff)) ||
                     (len_next > CalcWidth'(LenMask));

   // The payload count saturates at the largest value it holds.
   assign count_inc = (cur_count != LenMask) ? cur_count + 1'b1 : cur_count;

   always_comb begin
      phase_in         = cur_phase;
      frame_len_in     = cur_len;
      pay_count_in     = cur_count;
      first_pending_in = cur_first;
      out_status_in    = STATUS_HEADER;
      out_byte_in      = 8'd0;
      out_last_in      = 1'b0;
      out_ident_in     = 1'b0;

      case (cur_phase)
         PHASE_WAIT: begin
            if (in_byte_ff == CHAR_START) begin
               phase_in     = PHASE_LEN;
               frame_len_in = '0;
               pay_count_in = '0;
            end else begin
               out_status_in = STATUS_PROTO;
               phase_in      = PHASE_ERR;
            end
         end
         PHASE_LEN: begin
            if (is_digit) begin
               if (too_big) begin
                  out_status_in = STATUS_TOOBIG;
                  phase_in      = PHASE_ERR;
               end else begin
                  frame_len_in = len_next[LENGTH_WIDTH-1:0];
               end
            end else if (in_byte_ff == CHAR_COLON) begin
               phase_in     = PHASE_DATA;
               pay_count_in = '0;
            end else begin
               out_status_in = STATUS_PROTO;
               phase_in      = PHASE_ERR;
            end
         end
         PHASE_DATA: begin
            out_status_in = STATUS_PAYLOAD;
            out_byte_in   = in_byte_ff;
            out_ident_in  = cur_first;
            pay_count_in  = count_inc;
            // A zero length frame also ends on its first payload byte.
            if (count_inc >= cur_len) begin
               out_last_in      = 1'b1;
               first_pending_in = 1'b0;
               phase_in         = PHASE_WAIT;
               pay_count_in     = '0;
               frame_len_in     = '0;
            end
         end
         default: begin
            // Latched error: answer every byte with a protocol error.
            out_status_in = STATUS_PROTO;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         phase_ff         <= PHASE_WAIT;
         frame_len_ff     <= '0;
         pay_count_ff     <= '0;
         first_pending_ff <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff         <= phase_in;
            frame_len_ff     <= frame_len_in;
            pay_count_ff     <= pay_count_in;
            first_pending_ff <= first_pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_newconn_ff <= in_newconn_in;
      if (advance) begin
         out_status_ff <= out_status_in;
         out_byte_ff   <= out_byte_in;
         out_last_ff   <= out_last_in;
         out_ident_ff  <= out_ident_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_ident_ff, out_status_ff};

endmodule

`default_nettype wire
